// ===== rtl/core/positional_list_engine_unit_assert.svh =====
// Assertion macros shared by the positional list engine RTL.
// Used by modules that carry concurrent checks; no other dependencies.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("positional list engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("positional list engine check failed");

`endif

// ===== rtl/core/ple_pkg.sv =====
// Package for the positional list engine: sizes, command codes and word types.
// Used by every module of the block except ple_ram; depends on nothing.
package ple_pkg;

  // List capacity and derived widths.
  localparam int CAPACITY = 32;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  // Fixed field widths.
  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;

  // Queue sizes between the stages and at the result side.
  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Command codes of the input word.
  localparam logic [CMD_W-1:0] CMD_FRONT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BACK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // Operation kinds decided by the front stage.
  typedef enum logic [1:0] {
    OP_NONE       = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_REMOVE     = 2'd3
  } op_kind_e;

  // Back stage sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_DUMP  = 3'b100
  } back_state_e;

  // Input word.
  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic signed [VALUE_W-1:0] element;
    logic                      is_last;
    logic                      list_empty;
    logic                      insert_dropped;
  } res_t;

  // Classified operation passed from the front stage to the back stage.
  typedef struct packed {
    op_kind_e                  kind;
    logic                      dropped;
    logic signed [VALUE_W-1:0] value;
    logic [LEN_W-1:0]          pos;
    logic [LEN_W-1:0]          new_len;
  } op_t;

  // Physical slot of a logical index in the circular entry store.
  function automatic logic [IDX_W-1:0] phys_addr(logic [IDX_W-1:0] head,
                                                 logic [LEN_W-1:0] ofs);
    logic [LEN_W:0] sum;
    sum = (LEN_W+1)'(head) + (LEN_W+1)'(ofs);
    if (sum >= (LEN_W+1)'(CAPACITY)) begin
      sum = sum - (LEN_W+1)'(CAPACITY);
    end
    return IDX_W'(sum);
  endfunction

endpackage

// ===== rtl/core/ple_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ple_front.sv =====
// Front stage: accepts command words, tracks the list length and classifies
// each command into an operation for the back stage. Depends on ple_pkg.
module ple_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ple_pkg::cmd_t cmd_i,
  input  logic          q_full_i,
  output logic          full_o,
  output logic          op_push_o,
  output ple_pkg::op_t  op_o
);
  import ple_pkg::*;

  localparam int CmpW = (POS_W > LEN_W) ? POS_W : LEN_W;

  logic [LEN_W-1:0] len_q, len_d;
  logic [CmpW-1:0]  pos_ext;
  logic [CmpW-1:0]  len_ext;
  logic             accept;

  assign full_o    = q_full_i;
  assign accept    = push_i && !q_full_i;
  assign op_push_o = accept;
  assign pos_ext   = CmpW'(cmd_i.position);
  assign len_ext   = CmpW'(len_q);

  // Classify the command against the current length.
  always_comb begin
    op_o.kind    = OP_NONE;
    op_o.dropped = 1'b0;
    op_o.value   = cmd_i.value;
    op_o.pos     = LEN_W'(pos_ext);
    op_o.new_len = len_q;
    if (cmd_i.command == CMD_FRONT || cmd_i.command == CMD_BACK) begin
      if (len_q == LEN_W'(CAPACITY)) begin
        op_o.dropped = 1'b1;
      end else begin
        op_o.kind    = (cmd_i.command == CMD_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        op_o.new_len = len_q + LEN_W'(1);
      end
    end else if (cmd_i.command == CMD_DELETE) begin
      if (pos_ext < len_ext) begin
        op_o.kind    = OP_REMOVE;
        op_o.new_len = len_q - LEN_W'(1);
      end
    end
  end

  // Length follows every accepted word.
  assign len_d = accept ? op_o.new_len : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

endmodule

// ===== rtl/core/ple_opq.sv =====
// Short queue of classified operations between the front and back stages.
// Depends on ple_pkg for the operation type and queue size.
module ple_opq (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ple_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output ple_pkg::op_t op_o
);
  import ple_pkg::*;

  op_t                  slot_q [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OPQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OPQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + OPQ_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + OPQ_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + OPQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - OPQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// ===== rtl/core/ple_back.sv =====
// Back stage: applies operations to the circular entry store and dumps the
// list into the result queue. Depends on ple_pkg, ple_ram and the assert macros.
`include "positional_list_engine_unit_assert.svh"

module ple_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  ple_pkg::op_t  op_i,
  output logic          op_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output ple_pkg::res_t res_o
);
  import ple_pkg::*;

  back_state_e          state_q, state_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [LEN_W-1:0]     k_q, k_d;
  logic                 dropped_q, dropped_d;
  logic                 wr_pend_q, wr_pend_d;
  logic [LEN_W-1:0]     wr_idx_q, wr_idx_d;
  logic                 rd_pend_q, rd_pend_d;
  logic                 rd_last_q, rd_last_d;
  logic                 rd_drop_q, rd_drop_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [VALUE_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [VALUE_W-1:0]   ram_rdata;

  res_t                 res_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] res_wr_q, res_wr_d;
  logic [RES_PTR_W-1:0] res_rd_q, res_rd_d;
  logic [RES_CNT_W-1:0] res_cnt_q, res_cnt_d;
  logic                 res_push;
  res_t                 res_wdata;
  logic                 res_pop;
  logic                 space;

  // Entry store, indexed by physical slot.
  ple_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A dump read may issue only if the result queue can take its word.
  assign space = ((RES_CNT_W+1)'(res_cnt_q) + (RES_CNT_W+1)'(rd_pend_q))
                 < (RES_CNT_W+1)'(RES_DEPTH);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    len_d     = len_q;
    k_d       = k_q;
    dropped_d = dropped_q;
    wr_pend_d = 1'b0;
    wr_idx_d  = wr_idx_q;
    rd_pend_d = 1'b0;
    rd_last_d = rd_last_q;
    rd_drop_d = rd_drop_q;
    op_pop_o  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = phys_addr(head_q, wr_idx_q);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = phys_addr(head_q, k_q);
    res_push  = 1'b0;
    res_wdata = '{element: ram_rdata, is_last: rd_last_q, list_empty: 1'b0,
                  insert_dropped: rd_drop_q};

    // Finish a shift move: data read last cycle goes one slot down.
    if (wr_pend_q) begin
      ram_we = 1'b1;
    end

    // Deliver a dump word read last cycle.
    if (rd_pend_q) begin
      res_push = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          op_pop_o  = 1'b1;
          dropped_d = op_i.dropped;
          len_d     = op_i.new_len;
          k_d       = '0;
          state_d   = ST_DUMP;
          unique case (op_i.kind)
            OP_PUSH_FRONT: begin
              head_d    = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
              ram_we    = 1'b1;
              ram_waddr = head_d;
              ram_wdata = op_i.value;
            end
            OP_PUSH_BACK: begin
              ram_we    = 1'b1;
              ram_waddr = phys_addr(head_q, len_q);
              ram_wdata = op_i.value;
            end
            OP_REMOVE: begin
              k_d     = op_i.pos + LEN_W'(1);
              state_d = ST_SHIFT;
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // Move each later element one place toward the front.
        if (k_q <= len_q) begin
          ram_re    = 1'b1;
          wr_pend_d = 1'b1;
          wr_idx_d  = k_q - LEN_W'(1);
          k_d       = k_q + LEN_W'(1);
        end else if (!wr_pend_q) begin
          k_d     = '0;
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (len_q == '0) begin
          if (space && !rd_pend_q) begin
            res_push  = 1'b1;
            res_wdata = '{element: '0, is_last: 1'b1, list_empty: 1'b1,
                          insert_dropped: dropped_q};
            state_d   = ST_IDLE;
          end
        end else if (space) begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_last_d = (k_q == len_q - LEN_W'(1));
          rd_drop_d = dropped_q;
          k_d       = k_q + LEN_W'(1);
          if (rd_last_d) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      len_q     <= '0;
      k_q       <= '0;
      dropped_q <= 1'b0;
      wr_pend_q <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      len_q     <= len_d;
      k_q       <= k_d;
      dropped_q <= dropped_d;
      wr_pend_q <= wr_pend_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  // Side data of in-flight reads.
  always_ff @(posedge clk_i) begin
    wr_idx_q  <= wr_idx_d;
    rd_last_q <= rd_last_d;
    rd_drop_q <= rd_drop_d;
  end

  // Result queue control.
  assign empty_o = (res_cnt_q == '0);
  assign res_o   = res_q[res_rd_q];
  assign res_pop = pop_i && !empty_o;

  always_comb begin
    res_wr_d  = res_wr_q;
    res_rd_d  = res_rd_q;
    res_cnt_d = res_cnt_q;
    if (res_push) begin
      res_wr_d = res_wr_q + RES_PTR_W'(1);
    end
    if (res_pop) begin
      res_rd_d = res_rd_q + RES_PTR_W'(1);
    end
    if (res_push && !res_pop) begin
      res_cnt_d = res_cnt_q + RES_CNT_W'(1);
    end else if (res_pop && !res_push) begin
      res_cnt_d = res_cnt_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      res_wr_q  <= res_wr_d;
      res_rd_q  <= res_rd_d;
      res_cnt_q <= res_cnt_d;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wr_q] <= res_wdata;
    end
  end

  // Stored words plus the read in flight never exceed the queue depth.
  `PLE_ASSERT_IMP(a_credit_bound, clk_i, rst_ni, 1'b1, ((RES_CNT_W+1)'(res_cnt_q) + (RES_CNT_W+1)'(rd_pend_q)) <= (RES_CNT_W+1)'(RES_DEPTH))
  // A pending shift write only happens while shifting.
  `PLE_ASSERT_IMP(a_shift_write_in_shift, clk_i, rst_ni, wr_pend_q, state_q == ST_SHIFT)
  // Issuing the final dump read returns the sequencer to idle.
  `PLE_ASSERT_IMP(a_last_read_ends_dump, clk_i, rst_ni, rd_pend_q && rd_last_q, state_q == ST_IDLE)
  // An insert at the front goes straight to the dump with the new length.
  `PLE_ASSERT_NXT(a_push_front_to_dump, clk_i, rst_ni, (state_q == ST_IDLE) && op_valid_i && (op_i.kind == OP_PUSH_FRONT), (state_q == ST_DUMP) && (len_q == $past(op_i.new_len)))

endmodule

// ===== rtl/core/positional_list_engine_unit.sv =====
// Top level of the positional list engine.
// Depends on ple_pkg, ple_front, ple_opq and ple_back.

// Keeps an ordered list of up to CAPACITY signed 32-bit words and, after every
// command (insert at front, insert at back, delete at position), dumps the whole
// list front to back, last word marked; an empty list gives one word flagged empty
// and an insert into a full list is refused and flagged on every word of its dump.
// The back stage streams the dump at one word per cycle while the result queue has
// room, from the single read port of the entry RAM, and takes the next command
// only after the whole dump has been issued. A delete at position p from a list of
// N words first moves the N - p - 1 later words down through that same port, one
// per cycle, before the dump starts. Inserts at either end need a single RAM write
// thanks to a circular head pointer. The entry RAM needs no clearing after reset;
// only words already written are ever read. Up to two commands are buffered ahead
// of the back stage and up to four results behind it.
module positional_list_engine_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  ple_pkg::cmd_t cmd_i,
  output logic          empty,
  input  logic          pop,
  output ple_pkg::res_t res_o
);
  import ple_pkg::*;

  logic q_full;
  logic op_push;
  op_t  op_in;
  logic op_valid;
  op_t  op_out;
  logic op_pop;

  // Accept and classify commands.
  ple_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .cmd_i     (cmd_i),
    .q_full_i  (q_full),
    .full_o    (full),
    .op_push_o (op_push),
    .op_o      (op_in)
  );

  // Decouple the two stages.
  ple_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .op_i    (op_in),
    .full_o  (q_full),
    .pop_i   (op_pop),
    .valid_o (op_valid),
    .op_o    (op_out)
  );

  // Apply operations and dump the list.
  ple_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op_out),
    .op_pop_o   (op_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res_o)
  );

endmodule

// ===== test/positional_list_engine_unit_test.sv =====
// Self-checking testbench for positional_list_engine_unit: commands go in through a queue
// interface, and each list dump that comes back is checked against a mirrored copy of the list.
// Depends on ple_pkg and the RTL of positional_list_engine_unit.
`timescale 1ns / 100ps

module positional_list_engine_unit_test;
  import ple_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 350;
  localparam int CALM_TAIL    = 40;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  cmd_t cmd_i  = '0;
  logic full;
  logic empty;
  res_t res_o;

  // Stimulus and checking state.
  cmd_t                      pending_cmds[$];
  logic signed [VALUE_W-1:0] mirror_list[$];
  res_t                      awaited_words[$];
  logic                      cmd_taken    = 1'b0;
  logic                      loading_done = 1'b0;
  int                        cmd_gap      = 0;
  int                        res_gap      = 0;
  int                        cycles       = 0;
  int                        errors       = 0;
  int                        est_len      = 0;

  positional_list_engine_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .cmd_i  (cmd_i),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one command to the mirrored list and queue the dump it should produce.
  function automatic void apply_command(cmd_t c);
    logic dropped;
    res_t r;
    dropped = 1'b0;
    case (c.command)
      CMD_FRONT, CMD_BACK: begin
        if (mirror_list.size() >= CAPACITY) begin
          dropped = 1'b1;
        end else if (c.command == CMD_FRONT) begin
          mirror_list.push_front(c.value);
        end else begin
          mirror_list.push_back(c.value);
        end
      end
      CMD_DELETE: begin
        if (int'(c.position) < mirror_list.size()) begin
          mirror_list.delete(int'(c.position));
        end
      end
      default: ;
    endcase
    if (mirror_list.size() == 0) begin
      r.element        = '0;
      r.is_last        = 1'b1;
      r.list_empty     = 1'b1;
      r.insert_dropped = dropped;
      awaited_words.push_back(r);
    end else begin
      foreach (mirror_list[i]) begin
        r.element        = mirror_list[i];
        r.is_last        = (i == mirror_list.size() - 1);
        r.list_empty     = 1'b0;
        r.insert_dropped = dropped;
        awaited_words.push_back(r);
      end
    end
  endfunction

  // Compare one received result word with the oldest awaited one.
  function automatic void check_word(res_t got);
    res_t want;
    if (awaited_words.size() == 0) begin
      $error("unexpected result word: element %0d", got.element);
      errors++;
      return;
    end
    want = awaited_words.pop_front();
    if (got.element !== want.element) begin
      $error("element: expected %0d, actual %0d", want.element, got.element);
      errors++;
    end
    if (got.is_last !== want.is_last) begin
      $error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
      errors++;
    end
    if (got.list_empty !== want.list_empty) begin
      $error("list_empty: expected %0b, actual %0b", want.list_empty, got.list_empty);
      errors++;
    end
    if (got.insert_dropped !== want.insert_dropped) begin
      $error("insert_dropped: expected %0b, actual %0b", want.insert_dropped,
             got.insert_dropped);
      errors++;
    end
  endfunction

  // Queue a command and keep a rough length so that deletes can aim inside the list.
  function automatic void add_cmd(logic [CMD_W-1:0] op, logic [VALUE_W-1:0] val,
                                  logic [POS_W-1:0] pos);
    cmd_t c;
    c.command  = op;
    c.value    = val;
    c.position = pos;
    pending_cmds.push_back(c);
    if ((op == CMD_FRONT || op == CMD_BACK) && est_len < CAPACITY) begin
      est_len++;
    end else if (op == CMD_DELETE && int'(pos) < est_len) begin
      est_len--;
    end
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (est_len > 0 && $urandom_range(0, 9) < 7) begin
      return POS_W'($urandom_range(0, est_len - 1));
    end
    return POS_W'($urandom_range(0, 63));
  endfunction

  // Monitor: accept words on both sides at the rising edge, and watch the cycle limit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (push && !full) begin
        apply_command(cmd_i);
        cmd_taken = 1'b1;
      end
      if (pop && !empty) begin
        check_word(res_o);
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Command driver: presents the head of the pending queue, with random idle bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cmd_taken) begin
        void'(pending_cmds.pop_front());
        cmd_taken = 1'b0;
      end
      if (cmd_gap > 0) begin
        cmd_gap--;
      end else if (!(loading_done && pending_cmds.size() < CALM_TAIL) &&
                   $urandom_range(0, 15) == 0) begin
        cmd_gap = $urandom_range(1, 10);
      end
      if (cmd_gap == 0 && pending_cmds.size() > 0) begin
        push  <= 1'b1;
        cmd_i <= pending_cmds[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result driver: pop is held low during random stall bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_gap > 0) begin
        res_gap--;
      end else if (!(loading_done && pending_cmds.size() < CALM_TAIL) &&
                   $urandom_range(0, 7) == 0) begin
        res_gap = $urandom_range(1, 10);
      end
      pop <= (res_gap == 0);
    end
  end

  // Stimulus, end of run and verdict.
  initial begin
    int count;
    int mode;
    int run_len;
    int pick;

    // Directed part: empty-list cases, extreme values, every kind of delete, unused code.
    add_cmd(CMD_DELETE, 32'h0, 6'd0);
    add_cmd(CMD_DELETE, 32'h1234_5678, 6'd63);
    add_cmd(CMD_UNUSED, 32'hffff_ffff, 6'd63);
    add_cmd(CMD_FRONT, 32'h7fff_ffff, 6'd0);
    add_cmd(CMD_BACK, 32'h8000_0000, 6'd0);
    add_cmd(CMD_FRONT, 32'h0000_0000, 6'd0);
    add_cmd(CMD_BACK, 32'hffff_ffff, 6'd0);
    add_cmd(CMD_FRONT, 32'h0000_0001, 6'd0);
    add_cmd(CMD_DELETE, 32'h0, 6'd63);
    add_cmd(CMD_DELETE, 32'h0, 6'd5);
    add_cmd(CMD_DELETE, 32'h0, 6'd2);
    add_cmd(CMD_DELETE, 32'h0, 6'd3);
    add_cmd(CMD_DELETE, 32'h0, 6'd0);
    add_cmd(CMD_UNUSED, 32'h0, 6'd0);
    add_cmd(CMD_FRONT, 32'h0000_0002, 6'd63);
    add_cmd(CMD_DELETE, 32'hffff_ffff, 6'd1);
    add_cmd(CMD_BACK, 32'h5555_5555, 6'd42);
    add_cmd(CMD_FRONT, 32'haaaa_aaaa, 6'd21);
    repeat (4) add_cmd(CMD_DELETE, 32'h0, 6'd0);
    add_cmd(CMD_DELETE, 32'h0, 6'd1);

    // Random part in runs: fill to full and beyond, drain, or a mix.
    count = 0;
    while (count < RANDOM_WORDS) begin
      mode = $urandom_range(0, 2);
      if (mode == 0) begin
        while (est_len < CAPACITY) begin
          add_cmd($urandom_range(0, 1) ? CMD_BACK : CMD_FRONT, pick_value(),
                  POS_W'($urandom));
          count++;
        end
        run_len = $urandom_range(1, 4);
        repeat (run_len) begin
          add_cmd($urandom_range(0, 1) ? CMD_BACK : CMD_FRONT, pick_value(),
                  POS_W'($urandom));
          count++;
        end
      end else begin
        run_len = $urandom_range(15, 50);
        repeat (run_len) begin
          pick = $urandom_range(0, 99);
          if (pick < ((mode == 1) ? 20 : 45)) begin
            add_cmd($urandom_range(0, 1) ? CMD_BACK : CMD_FRONT, pick_value(),
                    POS_W'($urandom));
          end else if (pick < 95) begin
            add_cmd(CMD_DELETE, $urandom, pick_position());
          end else begin
            add_cmd(CMD_UNUSED, $urandom, POS_W'($urandom));
          end
          count++;
        end
      end
    end
    loading_done = 1'b1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every command to go in and every dump word to come back.
    while (pending_cmds.size() > 0 || awaited_words.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_ram.sv
rtl/core/ple_front.sv
rtl/core/ple_opq.sv
rtl/core/ple_back.sv
rtl/core/positional_list_engine_unit.sv
test/positional_list_engine_unit_test.sv
